// File: rtl/sacm_pkg.sv
// sacm_pkg: shared constants and types for the spectral-angle color matcher.
// Used by sacm_ref_lane, sacm_flow and spectral_angle_color_match_core.
// No dependencies.
package sacm_pkg;

  // default channel width and number of reference colors
  localparam int unsigned CHANNEL_BITS_DEF = 8;
  localparam int unsigned NUM_REFS         = 2;
  localparam int unsigned REF_IDX_W        = $clog2(NUM_REFS);

  // register map: four registers per reference
  localparam int unsigned FIELD_W   = 2;
  localparam int unsigned CFG_IDX_W = REF_IDX_W + FIELD_W;

  typedef enum logic [FIELD_W-1:0] {
    FLD_COLOR = 2'd0,
    FLD_TOL   = 2'd1,
    FLD_COS   = 2'd2,
    FLD_EN    = 2'd3
  } reg_field_e;

  // squared cosine is Q1.16: one integer bit so that 1.0 fits
  localparam int unsigned COS_FRAC = 16;
  localparam int unsigned COS_W    = COS_FRAC + 1;

  // register stages inside one reference lane
  localparam int unsigned LANE_STAGES = 6;

  // reset contents of the reference registers
  localparam int unsigned REF_COLOR_RST [NUM_REFS] = '{32'd6571592, 32'd1251094};
  localparam int unsigned REF_TOL_RST   [NUM_REFS] = '{32'd30, 32'd50};
  localparam int unsigned REF_COS_RST   [NUM_REFS] = '{32'd64883, 32'd65536};
  localparam bit          REF_EN_RST    [NUM_REFS] = '{1'b1, 1'b0};

endpackage

// File: rtl/sacm_ref_lane.sv
// sacm_ref_lane: registers of one reference color and the six-stage pipeline
// that runs the angle and box tests of a pixel against it. Uses sacm_pkg.
module sacm_ref_lane #(
  parameter int unsigned CHANNEL_BITS = sacm_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned CFG_DW       = 24,
  parameter int unsigned LANE_ID      = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sacm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DW-1:0]                 cfg_data_i,
  input  logic [sacm_pkg::LANE_STAGES-1:0]  en_i,
  input  logic [CHANNEL_BITS-1:0]           pix_i [3],
  output logic                              match_o
);

  localparam int unsigned CB  = CHANNEL_BITS;
  localparam int unsigned CW  = 3 * CB;
  localparam int unsigned PW  = 2 * CB;                  // one product
  localparam int unsigned SW  = PW + 2;                  // sum of three
  localparam int unsigned QW  = 2 * SW;                  // square of a sum
  localparam int unsigned HW  = SW + sacm_pkg::COS_W;    // half product times cos
  localparam int unsigned RW  = QW + sacm_pkg::COS_W;    // right-hand side

  // ---------------- reference registers ----------------
  logic [CW-1:0]                 color_q;
  logic [CB-1:0]                 tol_q;
  logic [sacm_pkg::COS_W-1:0]    cos_q;
  logic                          en_q;
  logic                          sel;
  sacm_pkg::reg_field_e          fld;

  assign sel = cfg_we_i && (cfg_idx_i[sacm_pkg::CFG_IDX_W-1 -: sacm_pkg::REF_IDX_W] ==
                            sacm_pkg::REF_IDX_W'(LANE_ID));
  assign fld = sacm_pkg::reg_field_e'(cfg_idx_i[sacm_pkg::FIELD_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= CW'(sacm_pkg::REF_COLOR_RST[LANE_ID]);
      tol_q   <= CB'(sacm_pkg::REF_TOL_RST[LANE_ID]);
      cos_q   <= sacm_pkg::COS_W'(sacm_pkg::REF_COS_RST[LANE_ID]);
      en_q    <= sacm_pkg::REF_EN_RST[LANE_ID];
    end else if (sel) begin
      case (fld)
        sacm_pkg::FLD_COLOR: color_q <= cfg_data_i[CW-1:0];
        sacm_pkg::FLD_TOL:   tol_q   <= cfg_data_i[CB-1:0];
        sacm_pkg::FLD_COS:   cos_q   <= cfg_data_i[sacm_pkg::COS_W-1:0];
        sacm_pkg::FLD_EN:    en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [CB-1:0] ref_ch [3];
  assign ref_ch[0] = color_q[3*CB-1 -: CB];
  assign ref_ch[1] = color_q[2*CB-1 -: CB];
  assign ref_ch[2] = color_q[CB-1:0];

  // ---------------- stage 1: products and channel distances ----------------
  logic [PW-1:0] dot_term_q [3];
  logic [PW-1:0] tsq_q      [3];
  logic [PW-1:0] rsq_q      [3];
  logic [CB-1:0] absd_q     [3];
  logic [CB:0]   diff       [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = {1'b0, pix_i[k]} - {1'b0, ref_ch[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int k = 0; k < 3; k++) begin
        dot_term_q[k] <= PW'(pix_i[k]) * PW'(ref_ch[k]);
        tsq_q[k]      <= PW'(pix_i[k]) * PW'(pix_i[k]);
        rsq_q[k]      <= PW'(ref_ch[k]) * PW'(ref_ch[k]);
        absd_q[k]     <= diff[k][CB] ? CB'(-diff[k]) : diff[k][CB-1:0];
      end
    end
  end

  // ---------------- stage 2: sums, zero-norm and box tests ----------------
  logic [SW-1:0] dot_q, nt_q, nr_q;
  logic [SW-1:0] nt_sum, nr_sum;
  logic          zero2_q, box2_q;

  assign nt_sum = SW'(tsq_q[0]) + SW'(tsq_q[1]) + SW'(tsq_q[2]);
  assign nr_sum = SW'(rsq_q[0]) + SW'(rsq_q[1]) + SW'(rsq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      dot_q   <= SW'(dot_term_q[0]) + SW'(dot_term_q[1]) + SW'(dot_term_q[2]);
      nt_q    <= nt_sum;
      nr_q    <= nr_sum;
      zero2_q <= (nt_sum == '0) || (nr_sum == '0);
      // strict box: |pixel - ref| < tolerance on every channel
      box2_q  <= (absd_q[0] < tol_q) && (absd_q[1] < tol_q) && (absd_q[2] < tol_q);
    end
  end

  // ---------------- stage 3: dot squared, norm product ----------------
  logic [QW-1:0] dsq3_q, nn_q;
  logic          zero3_q, box3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      dsq3_q  <= QW'(dot_q) * QW'(dot_q);
      nn_q    <= QW'(nt_q) * QW'(nr_q);
      zero3_q <= zero2_q;
      box3_q  <= box2_q;
    end
  end

  // ---------------- stage 4: norm product times cos^2, two halves ----------------
  logic [QW-1:0] dsq4_q;
  logic [HW-1:0] phi_q, plo_q;
  logic          zero4_q, box4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      dsq4_q  <= dsq3_q;
      phi_q   <= HW'(nn_q[QW-1:SW]) * HW'(cos_q);
      plo_q   <= HW'(nn_q[SW-1:0]) * HW'(cos_q);
      zero4_q <= zero3_q;
      box4_q  <= box3_q;
    end
  end

  // ---------------- stage 5: join the halves ----------------
  logic [QW-1:0] dsq5_q;
  logic [RW-1:0] right_q;
  logic          zero5_q, box5_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      dsq5_q  <= dsq4_q;
      right_q <= (RW'(phi_q) << SW) + RW'(plo_q);
      zero5_q <= zero4_q;
      box5_q  <= box4_q;
    end
  end

  // ---------------- stage 6: angle compare and final match ----------------
  logic [RW-1:0] left;
  logic          match_q;

  assign left = {1'b0, dsq5_q, {sacm_pkg::COS_FRAC{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      match_q <= en_q && box5_q && (zero5_q || (left > right_q));
    end
  end

  assign match_o = match_q;

endmodule

// File: rtl/sacm_flow.sv
// sacm_flow: valid/motion bits that travel beside the lane pipeline, the
// per-stage advance enables and the output register. Uses sacm_pkg.
module sacm_flow (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              moving_i,
  input  logic                              out_stall_i,
  input  logic [sacm_pkg::NUM_REFS-1:0]     match_i,
  output logic [sacm_pkg::LANE_STAGES-1:0]  en_o,
  output logic [sacm_pkg::LANE_STAGES-1:0]  pipe_vld_o,
  output logic                              in_stall_o,
  output logic                              out_valid_o,
  output logic                              detected_o
);

  localparam int unsigned S = sacm_pkg::LANE_STAGES;

  logic [S-1:0] vld_q, mov_q, en;
  logic         out_en;
  logic         out_vld_q, det_q;

  // a stage advances when it is empty or the stage after it advances
  always_comb begin
    out_en   = !out_vld_q || !out_stall_i;
    en[S-1]  = !vld_q[S-1] || out_en;
    for (int k = S - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < S; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (out_en) begin
        out_vld_q <= vld_q[S-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mov_q[0] <= moving_i;
    end
    for (int k = 1; k < S; k++) begin
      if (en[k]) begin
        mov_q[k] <= mov_q[k-1];
      end
    end
    if (out_en) begin
      det_q <= mov_q[S-1] && (|match_i);
    end
  end

  assign en_o        = en;
  assign pipe_vld_o  = vld_q;
  assign in_stall_o  = !en[0];
  assign out_valid_o = out_vld_q;
  assign detected_o  = det_q;

endmodule

// File: rtl/spectral_angle_color_match_core.sv
// spectral_angle_color_match_core: top level of the per-pixel color matcher.
// Depends on sacm_pkg, sacm_ref_lane and sacm_flow.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-------------------------------------
//   in      | in_valid_i / in_stall_o   | red_i, green_i, blue_i, moving_i
//   out     | out_valid_o / out_stall_i | detected_o
//   cfg     | cfg_we_i                  | cfg_idx_i, cfg_data_i (no read-back)
//
// One pixel per clock while the output is not stalled; each beat passes
// six lane stages plus the output register, a depth set by the split
// product dot^2 vs |p|^2*|r|^2*cos^2 that is cut into two half multiplies.
// Reset clears all valid bits; reference registers take their defaults.
// A stall on the output fills bubbles first; the input stalls only when
// every stage and the output register hold a beat.
module spectral_angle_color_match_core #(
  parameter int unsigned CHANNEL_BITS = sacm_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic [CHANNEL_BITS-1:0]                   red_i,
  input  logic [CHANNEL_BITS-1:0]                   green_i,
  input  logic [CHANNEL_BITS-1:0]                   blue_i,
  input  logic                                      moving_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic                                      detected_o,
  input  logic                                      cfg_we_i,
  input  logic [sacm_pkg::CFG_IDX_W-1:0]            cfg_idx_i,
  input  logic [((3*CHANNEL_BITS > sacm_pkg::COS_W) ?
                 3*CHANNEL_BITS : sacm_pkg::COS_W)-1:0] cfg_data_i
);

  localparam int unsigned CFG_DW = (3 * CHANNEL_BITS > sacm_pkg::COS_W) ?
                                   3 * CHANNEL_BITS : sacm_pkg::COS_W;
  localparam int unsigned S      = sacm_pkg::LANE_STAGES;

  logic [CHANNEL_BITS-1:0]        pix [3];
  logic [S-1:0]                   en;
  logic [S-1:0]                   pipe_vld;
  logic [sacm_pkg::NUM_REFS-1:0]  match;

  assign pix[0] = red_i;
  assign pix[1] = green_i;
  assign pix[2] = blue_i;

  for (genvar g = 0; g < sacm_pkg::NUM_REFS; g++) begin : g_lane
    sacm_ref_lane #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .CFG_DW       (CFG_DW),
      .LANE_ID      (g)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cfg_we_i   (cfg_we_i),
      .cfg_idx_i  (cfg_idx_i),
      .cfg_data_i (cfg_data_i),
      .en_i       (en),
      .pix_i      (pix),
      .match_o    (match[g])
    );
  end

  sacm_flow u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .moving_i    (moving_i),
    .out_stall_i (out_stall_i),
    .match_i     (match),
    .en_o        (en),
    .pipe_vld_o  (pipe_vld),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .detected_o  (detected_o)
  );

  // input backs up only when the whole pipe is full and the output is held
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&pipe_vld) && out_valid_o && out_stall_i))
    else $error("input stalled with a free slot in the pipeline");

  // a taken beat with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !pipe_vld[S-1]) |=> !out_valid_o)
    else $error("output beat repeated after it was taken");

endmodule
